@@ src/lrutlb_pkg.sv @@
// Shared types and constants for the LRU translation buffer.
// No dependencies; compile first.
package lrutlb_pkg;

  localparam int DEFAULT_ENTRIES = 16;
  localparam int PAGE_W          = 20;
  localparam int FRAME_W         = 16;
  localparam int OCC_W           = 5;

  localparam logic FUNC_ADD    = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_UPD
  } tlb_state_t;

  // One translation held in a cell.
  typedef struct packed {
    logic               valid;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
  } entry_t;

  // Per-cell move command for one update cycle.
  typedef struct packed {
    logic take_prev;   // load from the more recent neighbor
    logic take_next;   // load from the less recent neighbor
  } cell_ctl_t;

endpackage

@@ src/lrutlb_if.sv @@
// Valid/ready channel interfaces for request and response beats.
// Depends on lrutlb_pkg.
interface lrutlb_req_if
  import lrutlb_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [PAGE_W-1:0]  vpn;
  logic [FRAME_W-1:0] pfn;

  modport source (output valid, func, vpn, pfn, input ready);
  modport sink   (input valid, func, vpn, pfn, output ready);
endinterface

interface lrutlb_rsp_if
  import lrutlb_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               was_present;
  logic               evicted;
  logic [PAGE_W-1:0]  evicted_page;
  logic [FRAME_W-1:0] evicted_frame;
  logic [OCC_W-1:0]   occupancy;
  logic               is_empty;

  modport source (output valid, was_present, evicted, evicted_page, evicted_frame,
                  occupancy, is_empty, input ready);
  modport sink   (input valid, was_present, evicted, evicted_page, evicted_frame,
                  occupancy, is_empty, output ready);
endinterface

@@ src/lrutlb_cell.sv @@
// One position of the recency list: holds an entry, compares its page,
// and loads from either neighbor when told to. Depends on lrutlb_pkg.
module lrutlb_cell
  import lrutlb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl,
  input  entry_t            prev_i,
  input  entry_t            next_i,
  input  logic [PAGE_W-1:0] req_page,
  output entry_t            ent_o,
  output logic              match_o
);

  logic               valid_r, valid_nxt;
  logic [PAGE_W-1:0]  page_r, page_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;

  always_comb begin
    valid_nxt = valid_r;
    page_nxt  = page_r;
    frame_nxt = frame_r;
    if (ctl.take_prev) begin
      valid_nxt = prev_i.valid;
      page_nxt  = prev_i.page;
      frame_nxt = prev_i.frame;
    end else if (ctl.take_next) begin
      valid_nxt = next_i.valid;
      page_nxt  = next_i.page;
      frame_nxt = next_i.frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r  <= page_nxt;
    frame_r <= frame_nxt;
  end

  assign ent_o   = '{valid: valid_r, page: page_r, frame: frame_r};
  assign match_o = valid_r && (page_r == req_page);

endmodule

@@ src/lru_tlb_table_top.sv @@
// Top level of the fully associative LRU translation buffer.
// Depends on lrutlb_pkg, lrutlb_if and lrutlb_cell.
//
// Usage:
//   in_ch carries request beats (func, vpn, pfn); func
//   add inserts or refreshes a mapping, func remove deletes one.
//   out_ch carries one response beat per request: hit flag, eviction
//   flag and evicted pair, and the occupancy after the request.
//   Entries live in a row of ENTRIES cells ordered by recency, cell 0
//   most recent. An update shifts part or all of the row by one cell.
// Timing:
//   A request is accepted, compared in all cells (match vector
//   registered), then applied in the row update, which loads the
//   response register. The next request is accepted the cycle after
//   the update at the earliest, so a new request is not taken before
//   the last one has been applied.
// Reset and stall:
//   Synchronous active-low reset empties the table and drops any
//   pending response. A response waiting on out_ch does not stop the
//   next request from being accepted and compared; its update waits
//   until the response register is free.
module lru_tlb_table_top
  import lrutlb_pkg::*;
#(
  parameter int ENTRIES = DEFAULT_ENTRIES
)(
  input  logic          clk,
  input  logic          rst_n,
  lrutlb_req_if.sink    in_ch,
  lrutlb_rsp_if.source  out_ch
);

  localparam int CNT_W = $clog2(ENTRIES + 1);

  tlb_state_t state_r, state_nxt;

  logic               req_func_r;
  logic [PAGE_W-1:0]  req_page_r;
  logic [FRAME_W-1:0] req_frame_r;

  logic [ENTRIES-1:0] match_c, match_r;
  logic [ENTRIES-1:0] at_or_after, at_or_before;
  entry_t             ent [ENTRIES];
  cell_ctl_t          ctl [ENTRIES];

  logic [CNT_W-1:0] count_r, count_nxt;

  logic               out_valid_r;
  logic               out_present_r, out_evicted_r, out_empty_r;
  logic [PAGE_W-1:0]  out_ev_page_r;
  logic [FRAME_W-1:0] out_ev_frame_r;
  logic [OCC_W-1:0]   out_occ_r;

  logic accept, look_en, upd_en, hit, full, do_evict;

  // ---- control ----
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_ch.valid) state_nxt = S_LOOK;
      S_LOOK:  state_nxt = S_UPD;
      S_UPD:   if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    look_en     = 1'b0;
    upd_en      = 1'b0;
    case (state_r)
      S_IDLE:  in_ch.ready = 1'b1;
      S_LOOK:  look_en = 1'b1;
      S_UPD:   upd_en = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  assign accept = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_func_r  <= in_ch.func;
      req_page_r  <= in_ch.vpn;
      req_frame_r <= in_ch.pfn;
    end
    if (look_en) begin
      match_r <= match_c;
    end
  end

  // ---- cell row ----
  // Pages are unique, so match_r is one-hot or zero; each flag below is an
  // independent reduction over a masked copy of it.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      logic [ENTRIES-1:0] lo_mask;
      lo_mask         = ENTRIES'((2 * ({{(ENTRIES-1){1'b0}}, 1'b1} << i)) - 1);
      at_or_after[i]  = |(match_r & lo_mask);
      at_or_before[i] = |(match_r & ~(lo_mask >> 1));
    end
  end

  assign hit      = |match_r;
  assign full     = (count_r == CNT_W'(ENTRIES));
  assign do_evict = (req_func_r == FUNC_ADD) && !hit && full;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      ctl[i] = '{take_prev: 1'b0, take_next: 1'b0};
      if (upd_en) begin
        if (req_func_r == FUNC_ADD) begin
          // refresh: shift down through the hit cell; insert: shift all
          ctl[i].take_prev = hit ? at_or_before[i] : 1'b1;
        end else begin
          ctl[i].take_next = at_or_after[i];
        end
      end
    end
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    entry_t prev_d, next_d;
    if (g == 0) begin : g_head
      assign prev_d = '{valid: 1'b1, page: req_page_r, frame: req_frame_r};
    end else begin : g_mid
      assign prev_d = ent[g-1];
    end
    if (g == ENTRIES - 1) begin : g_tail
      assign next_d = '0;
    end else begin : g_body
      assign next_d = ent[g+1];
    end

    lrutlb_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl[g]),
      .prev_i   (prev_d),
      .next_i   (next_d),
      .req_page (req_page_r),
      .ent_o    (ent[g]),
      .match_o  (match_c[g])
    );
  end

  // ---- occupancy ----
  always_comb begin
    count_nxt = count_r;
    if (req_func_r == FUNC_ADD) begin
      if (!hit && !full) count_nxt = count_r + CNT_W'(1);
    end else if (hit) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (upd_en) begin
        count_r <= count_nxt;
      end
      if (upd_en) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---- response register ----
  always_ff @(posedge clk) begin
    if (upd_en) begin
      out_present_r  <= hit;
      out_evicted_r  <= do_evict;
      out_ev_page_r  <= do_evict ? ent[ENTRIES-1].page  : '0;
      out_ev_frame_r <= do_evict ? ent[ENTRIES-1].frame : '0;
      out_occ_r      <= OCC_W'(count_nxt);
      out_empty_r    <= (count_nxt == '0);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.was_present   = out_present_r;
  assign out_ch.evicted       = out_evicted_r;
  assign out_ch.evicted_page  = out_ev_page_r;
  assign out_ch.evicted_frame = out_ev_frame_r;
  assign out_ch.occupancy     = out_occ_r;
  assign out_ch.is_empty      = out_empty_r;

endmodule

@@ src/lrutlb_checker.sv @@
// Port-level checks for lru_tlb_table_top, attached by bind.
// Depends on lrutlb_pkg.
module lrutlb_checker
  import lrutlb_pkg::*;
#(
  parameter int ENTRIES = DEFAULT_ENTRIES
)(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_was_present,
  input logic               out_evicted,
  input logic [PAGE_W-1:0]  out_evicted_page,
  input logic [FRAME_W-1:0] out_evicted_frame,
  input logic [OCC_W-1:0]   out_occupancy,
  input logic               out_is_empty
);

  // stalled response beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_was_present, out_evicted, out_evicted_page, out_evicted_frame,
               out_occupancy, out_is_empty}))
    else $error("response beat changed while stalled");

  // one request in flight: no accept in the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted back to back");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_occupancy == '0)))
    else $error("is_empty disagrees with occupancy");

  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> !out_was_present &&
      (out_occupancy == OCC_W'(ENTRIES)))
    else $error("eviction without a full table miss");

  a_no_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted |-> (out_evicted_page == '0) && (out_evicted_frame == '0))
    else $error("evicted pair nonzero without eviction");

endmodule

bind lru_tlb_table_top lrutlb_checker #(.ENTRIES(ENTRIES)) u_lrutlb_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_was_present   (out_ch.was_present),
  .out_evicted       (out_ch.evicted),
  .out_evicted_page  (out_ch.evicted_page),
  .out_evicted_frame (out_ch.evicted_frame),
  .out_occupancy     (out_ch.occupancy),
  .out_is_empty      (out_ch.is_empty)
);
